/* design/ire_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ire_pkg;

  // field widths
  localparam int VALUE_W  = 12;
  localparam int SYMBOL_W = 8;

  // largest number with a Roman numeral
  localparam logic [VALUE_W-1:0] VALUE_MAX = 12'd3999;

  // ascii codes of the symbols
  localparam logic [SYMBOL_W-1:0] SYM_M    = 8'h4D;
  localparam logic [SYMBOL_W-1:0] SYM_D    = 8'h44;
  localparam logic [SYMBOL_W-1:0] SYM_C    = 8'h43;
  localparam logic [SYMBOL_W-1:0] SYM_L    = 8'h4C;
  localparam logic [SYMBOL_W-1:0] SYM_X    = 8'h58;
  localparam logic [SYMBOL_W-1:0] SYM_V    = 8'h56;
  localparam logic [SYMBOL_W-1:0] SYM_I    = 8'h49;
  localparam logic [SYMBOL_W-1:0] SYM_NONE = 8'h00;

  // program size and step counter width
  localparam int PROG_LEN = 20;
  localparam int PC_W     = $clog2(PROG_LEN);

  // start of each digit section and the stop step
  localparam logic [PC_W-1:0] STEP_TENS  = 5'd7;
  localparam logic [PC_W-1:0] STEP_UNITS = 5'd13;
  localparam logic [PC_W-1:0] STEP_STOP  = 5'd19;

  // micro operations
  typedef enum logic [2:0] {
    OP_LOOP,  // while value >= k: emit, subtract, hold step
    OP_ONCE,  // if value >= k: emit, subtract; next step
    OP_HEAD,  // if value >= k: emit first of a pair; else skip the tail
    OP_TAIL,  // emit second of a pair, subtract, jump
    OP_STOP
  } op_t;

  // one control word
  typedef struct packed {
    op_t                 op;
    logic [VALUE_W-1:0]  k;
    logic [SYMBOL_W-1:0] sym;
    logic [PC_W-1:0]     target;
  } ucode_t;

  // sequencer to datapath
  typedef struct packed {
    logic               load;
    logic               sub;
    logic [VALUE_W-1:0] k;
  } dp_ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic ge;
    logic rem_zero;
  } dp_status_t;

endpackage

`default_nettype wire

/* design/integer_to_roman_encoder.sv */
`timescale 1ns / 1ps
`default_nettype none

// Integer to Roman numeral encoder.
// Input channel: value (12 bits) with in_valid / in_stall; a transaction is
// taken when in_valid is high and in_stall is low. Output channel: symbol,
// last, error with out_valid / out_stall; one ASCII character per transaction,
// most significant first, last set on the final character.
// A value of 0 or above 3999 gives a single transaction with symbol 0,
// last 1 and error 1.
// One number is worked at a time: in_stall is high from acceptance until the
// final character has been loaded into the output register, so the next
// number can be taken while that character still waits to be taken.
// A microcoded sequencer steps through a 20-word program, one step a cycle
// unless a character waits under out_stall; each step emits at most one
// character or skips ahead. While a character waits under out_stall the
// sequencer holds its step and remainder. Synchronous reset clears the busy
// flag and the output valid; no transaction is in flight afterwards.

module integer_to_roman_encoder
  import ire_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [VALUE_W-1:0]  value,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [SYMBOL_W-1:0]      symbol,
  output logic                     last,
  output logic                     error
);

  logic            busy;
  logic            err_pend;
  logic [PC_W-1:0] pc;
  ucode_t          word;
  dp_ctrl_t        ctrl;
  dp_status_t      status;

  logic            in_take;
  logic            bad_value;
  logic            step_en;
  logic            emit;
  logic            emit_last;
  logic            done;
  logic [PC_W-1:0] pc_next;

  assign in_stall  = busy;
  assign in_take   = in_valid & ~busy;
  assign bad_value = (value == '0) || (value > VALUE_MAX);
  assign step_en   = busy & (~out_valid | ~out_stall);

  ire_ucode_rom u_rom (
    .pc   (pc),
    .word (word)
  );

  ire_datapath u_dp (
    .clk        (clk),
    .load_value (value),
    .ctrl       (ctrl),
    .status     (status)
  );

  // decode the current control word
  always_comb begin
    emit      = 1'b0;
    emit_last = 1'b0;
    done      = 1'b0;
    pc_next   = pc;
    ctrl.load = in_take;
    ctrl.sub  = 1'b0;
    ctrl.k    = word.k;
    if (step_en) begin
      if (err_pend) begin
        emit      = 1'b1;
        emit_last = 1'b1;
        done      = 1'b1;
      end else begin
        unique case (word.op)
          OP_LOOP: begin
            if (status.ge) begin
              emit      = 1'b1;
              emit_last = status.rem_zero;
              done      = status.rem_zero;
              ctrl.sub  = 1'b1;
            end else begin
              pc_next = pc + PC_W'(1);
            end
          end
          OP_ONCE: begin
            if (status.ge) begin
              emit      = 1'b1;
              emit_last = status.rem_zero;
              done      = status.rem_zero;
              ctrl.sub  = 1'b1;
            end
            pc_next = pc + PC_W'(1);
          end
          OP_HEAD: begin
            if (status.ge) begin
              emit    = 1'b1;
              pc_next = pc + PC_W'(1);
            end else begin
              pc_next = pc + PC_W'(2);
            end
          end
          OP_TAIL: begin
            emit      = 1'b1;
            emit_last = status.rem_zero;
            done      = status.rem_zero;
            ctrl.sub  = 1'b1;
            pc_next   = word.target;
          end
          default: begin
            done = 1'b1;
          end
        endcase
      end
    end
  end

  // sequencer state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      err_pend  <= 1'b0;
      pc        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_take) begin
        busy     <= 1'b1;
        err_pend <= bad_value;
        pc       <= '0;
      end else if (step_en) begin
        pc <= pc_next;
        if (done) begin
          busy <= 1'b0;
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (emit) begin
      symbol <= err_pend ? SYM_NONE : word.sym;
      last   <= emit_last;
      error  <= err_pend;
    end
  end

`ifndef SYNTHESIS
  // an error transaction is a lone, empty, final character
  a_error_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> last && (symbol == SYM_NONE))
    else $error("error transaction without last or with a symbol");

  // a bad number is flagged on acceptance
  a_bad_flagged: assert property (@(posedge clk) disable iff (rst)
    in_take && bad_value |=> busy && err_pend)
    else $error("out of range value not flagged");

  // step counter stays inside the program
  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> pc <= STEP_STOP)
    else $error("step counter outside program");

  // the final character ends the number
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    emit && emit_last |=> !busy && out_valid && last)
    else $error("final character did not end the number");

  // a new number is never taken while the remainder is in use
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_take)
    else $error("number taken while busy");
`endif

endmodule

`default_nettype wire

/* design/ire_ucode_rom.sv */
`timescale 1ns / 1ps
`default_nettype none

module ire_ucode_rom
  import ire_pkg::*;
(
  input  wire logic [PC_W-1:0] pc,
  output ucode_t               word
);

  // greedy program: thousands, hundreds, tens, units
  always_comb begin
    unique case (pc)
      5'd0:    word = '{OP_LOOP, 12'd1000, SYM_M, 5'd0};
      5'd1:    word = '{OP_HEAD, 12'd900,  SYM_C, 5'd0};
      5'd2:    word = '{OP_TAIL, 12'd900,  SYM_M, STEP_TENS};
      5'd3:    word = '{OP_ONCE, 12'd500,  SYM_D, 5'd0};
      5'd4:    word = '{OP_HEAD, 12'd400,  SYM_C, 5'd0};
      5'd5:    word = '{OP_TAIL, 12'd400,  SYM_D, STEP_TENS};
      5'd6:    word = '{OP_LOOP, 12'd100,  SYM_C, 5'd0};
      5'd7:    word = '{OP_HEAD, 12'd90,   SYM_X, 5'd0};
      5'd8:    word = '{OP_TAIL, 12'd90,   SYM_C, STEP_UNITS};
      5'd9:    word = '{OP_ONCE, 12'd50,   SYM_L, 5'd0};
      5'd10:   word = '{OP_HEAD, 12'd40,   SYM_X, 5'd0};
      5'd11:   word = '{OP_TAIL, 12'd40,   SYM_L, STEP_UNITS};
      5'd12:   word = '{OP_LOOP, 12'd10,   SYM_X, 5'd0};
      5'd13:   word = '{OP_HEAD, 12'd9,    SYM_I, 5'd0};
      5'd14:   word = '{OP_TAIL, 12'd9,    SYM_X, STEP_STOP};
      5'd15:   word = '{OP_ONCE, 12'd5,    SYM_V, 5'd0};
      5'd16:   word = '{OP_HEAD, 12'd4,    SYM_I, 5'd0};
      5'd17:   word = '{OP_TAIL, 12'd4,    SYM_V, STEP_STOP};
      5'd18:   word = '{OP_LOOP, 12'd1,    SYM_I, 5'd0};
      default: word = '{OP_STOP, 12'd0,    SYM_NONE, STEP_STOP};
    endcase
  end

endmodule

`default_nettype wire

/* design/ire_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module ire_datapath
  import ire_pkg::*;
(
  input  wire logic               clk,
  input  wire logic [VALUE_W-1:0] load_value,
  input  wire dp_ctrl_t           ctrl,
  output dp_status_t              status
);

  logic [VALUE_W-1:0] rem;
  logic [VALUE_W:0]   diff;

  // compare and subtract share one adder
  assign diff            = {1'b0, rem} - {1'b0, ctrl.k};
  assign status.ge       = ~diff[VALUE_W];
  assign status.rem_zero = (diff[VALUE_W-1:0] == '0);

  // remainder register
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem <= load_value;
    end else if (ctrl.sub) begin
      rem <= diff[VALUE_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench
  import ire_pkg::*;
();

  localparam int RANDOM_ITEMS = 305;
  localparam int QUIET_ITEMS  = 60;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 30;

  // one expected character of a numeral
  typedef struct {
    logic [SYMBOL_W-1:0] symbol;
    logic                last;
    logic                error;
  } roman_char_t;

  // expected numerals and their comparison against the output channel
  class roman_scoreboard;
    roman_char_t expected_chars[$];
    int          fail_count;

    function new();
      fail_count = 0;
    endfunction

    // append one character of the numeral being built
    function void add_char(ref roman_char_t chars[$], input logic [SYMBOL_W-1:0] sym);
      roman_char_t c;
      c.symbol = sym;
      c.last   = 1'b0;
      c.error  = 1'b0;
      chars.push_back(c);
    endfunction

    // one decimal digit using its ones, five and tens symbols
    function void add_digit(ref roman_char_t chars[$], input int unsigned digit,
                            input logic [SYMBOL_W-1:0] one_sym,
                            input logic [SYMBOL_W-1:0] five_sym,
                            input logic [SYMBOL_W-1:0] ten_sym);
      int unsigned q;
      q = digit;
      if (q == 9) begin
        add_char(chars, one_sym);
        add_char(chars, ten_sym);
      end else if (q == 4) begin
        add_char(chars, one_sym);
        add_char(chars, five_sym);
      end else begin
        if (q >= 5) begin
          add_char(chars, five_sym);
          q = q - 5;
        end
        while (q > 0) begin
          add_char(chars, one_sym);
          q--;
        end
      end
    endfunction

    // accepted input transaction: work out its numeral
    function void note_value(input logic [VALUE_W-1:0] v);
      roman_char_t chars[$];
      roman_char_t c;
      int unsigned n;
      n = v;
      if (n == 0 || n > VALUE_MAX) begin
        c.symbol = SYM_NONE;
        c.last   = 1'b1;
        c.error  = 1'b1;
        expected_chars.push_back(c);
        return;
      end
      for (int i = 0; i < n / 1000; i++) add_char(chars, SYM_M);
      n = n % 1000;
      add_digit(chars, n / 100, SYM_C, SYM_D, SYM_M);
      n = n % 100;
      add_digit(chars, n / 10, SYM_X, SYM_L, SYM_C);
      add_digit(chars, n % 10, SYM_I, SYM_V, SYM_X);
      chars[chars.size() - 1].last = 1'b1;
      foreach (chars[i]) expected_chars.push_back(chars[i]);
    endfunction

    // accepted output transaction: compare with the oldest expectation
    function void check_char(input logic [SYMBOL_W-1:0] sym, input logic lst,
                             input logic err);
      roman_char_t c;
      if (expected_chars.size() == 0) begin
        $error("unexpected character: symbol %h last %b error %b", sym, lst, err);
        fail_count++;
        return;
      end
      c = expected_chars.pop_front();
      if (sym !== c.symbol) begin
        $error("symbol: expected %h, actual %h", c.symbol, sym);
        fail_count++;
      end
      if (lst !== c.last) begin
        $error("last: expected %b, actual %b", c.last, lst);
        fail_count++;
      end
      if (err !== c.error) begin
        $error("error: expected %b, actual %b", c.error, err);
        fail_count++;
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [VALUE_W-1:0]  value;
  logic                out_valid;
  logic                out_stall;
  logic [SYMBOL_W-1:0] symbol;
  logic                last;
  logic                error;

  roman_scoreboard sb;
  bit              tail_quiet;
  int              cycle_count = 0;

  integer_to_roman_encoder uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .value    (value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .symbol   (symbol),
    .last     (last),
    .error    (error)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // transactions on both channels and the run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_value(value);
      if (out_valid && !out_stall) sb.check_char(symbol, last, error);
    end
  end

  // receiver back-pressure in random bursts
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!tail_quiet && !rst && stall_left == 0 && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 18);
      if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // drive one number, called at a falling edge, returns at a falling edge
  task automatic send_value(input logic [VALUE_W-1:0] v);
    int gap;
    if (!tail_quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid = 1'b0;
      value = VALUE_W'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    value = v;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] random_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      if ($urandom_range(0, 1) == 0) return '0;
      return VALUE_W'($urandom_range(4000, 4095));
    end
    if (r == 1) begin
      // digits from the long ones: 3, 7, 8
      int unsigned d[3];
      d[0] = $urandom_range(0, 2);
      d[1] = $urandom_range(0, 2);
      d[2] = $urandom_range(0, 2);
      return VALUE_W'($urandom_range(1, 3) * 1000 +
                      (d[0] == 0 ? 3 : d[0] == 1 ? 7 : 8) * 100 +
                      (d[1] == 0 ? 3 : d[1] == 1 ? 7 : 8) * 10 +
                      (d[2] == 0 ? 3 : d[2] == 1 ? 7 : 8));
    end
    return VALUE_W'($urandom_range(1, 3999));
  endfunction

  // stimulus
  initial begin
    logic [VALUE_W-1:0] directed_values[$];
    sb = new();
    tail_quiet = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    value = '0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // extremes, subtractive pairs, five-symbols and out of range values
    directed_values = '{12'd0, 12'd1, 12'd3999, 12'd4000, 12'd4095, 12'd3888,
                        12'd4, 12'd9, 12'd40, 12'd90, 12'd400, 12'd900,
                        12'd5, 12'd50, 12'd500, 12'd1000, 12'd3000, 12'd3,
                        12'd8, 12'd1994, 12'd3444, 12'd2048, 12'd1365,
                        12'd2730, 12'd2222};
    foreach (directed_values[i]) send_value(directed_values[i]);

    // random numbers, no idling towards the end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - QUIET_ITEMS) tail_quiet = 1'b1;
      send_value(random_value());
    end
    in_valid = 1'b0;

    // drain
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/ire_pkg.sv
design/ire_ucode_rom.sv
design/ire_datapath.sv
design/integer_to_roman_encoder.sv
tb/testbench.sv
